@@ hw/rtl/equal_width_histogram_core_macros.svh @@
// assertion macros shared by the histogram rtl
// no dependencies
`ifndef EQUAL_WIDTH_HISTOGRAM_CORE_MACROS_SVH
`define EQUAL_WIDTH_HISTOGRAM_CORE_MACROS_SVH
`define EWH_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define EWH_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

@@ hw/rtl/ewh_pkg.sv @@
// types and constants of the equal-width histogram
// no dependencies
package ewh_pkg;
  localparam int unsigned SampleW = 32;
  localparam int unsigned CountW  = 13;
  localparam int unsigned BinCfgW = 7;
  localparam int unsigned BinIdxW = 6;
  localparam logic [CountW-1:0] CountSat = 13'd8191;
  localparam logic [BinCfgW-1:0] BinCountRst = 7'd16;

  typedef enum logic [2:0] {
    ST_LOAD, ST_DIV_STEP, ST_CLEAR, ST_BIN_READ, ST_BIN_DIV, ST_EMIT
  } state_e;

  typedef struct packed {
    logic store;      // store sample and update min/max
    logic flag_drop;
    logic step_start; // begin range / nb division
    logic bin_start;  // begin (x-min)/step division on read data
    logic bin_commit; // add one to count of finished division
    logic clr_start;
    logic emit_load;
    logic set_clear;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic clr_done;
    logic scan_done;  // all stored samples read
    logic emit_done;
    logic out_free;
  } sts_t;
endpackage

@@ hw/rtl/ewh_if.sv @@
// valid/ready channel interface
// depends on nothing
interface ewh_if #(parameter int unsigned W = 1);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ hw/rtl/ewh_div.sv @@
// iterative 32-bit unsigned divider, one quotient bit a cycle
// depends on ewh_pkg
module ewh_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  import ewh_pkg::*;
  logic [5:0] cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d, den_q, den_d;
  logic [32:0] rem_q, rem_d, trial;

  assign trial = {rem_q[31:0], quo_q[31]};
  always_comb begin
    cnt_d = cnt_q; quo_d = quo_q; rem_d = rem_q; den_d = den_q;
    if (start_i) begin
      cnt_d = 6'd32; quo_d = num_i; rem_d = '0; den_d = den_i;
    end else if (cnt_q != 6'd0) begin
      cnt_d = cnt_q - 6'd1;
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
    end
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end
  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end
  assign busy_o = (cnt_q != 6'd0);
  assign quo_o = quo_q;
endmodule

@@ hw/rtl/ewh_ctrl.sv @@
// controller state machine of the histogram
// depends on ewh_pkg
module ewh_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_last_i,
  input  logic          full_i,
  output logic          in_ready_o,
  input  ewh_pkg::sts_t sts_i,
  output ewh_pkg::cmd_t cmd_o
);
  import ewh_pkg::*;
  `include "equal_width_histogram_core_macros.svh"
  state_e state_q, state_d;
  logic acc;

  assign in_ready_o = (state_q == ST_LOAD);
  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD:     if (acc && in_last_i) state_d = ST_DIV_STEP;
      ST_DIV_STEP: if (!sts_i.div_busy) state_d = ST_CLEAR;
      ST_CLEAR:    if (sts_i.clr_done) state_d = ST_BIN_READ;
      ST_BIN_READ: if (sts_i.scan_done) state_d = ST_EMIT;
                   else state_d = ST_BIN_DIV;
      ST_BIN_DIV:  if (!sts_i.div_busy) state_d = ST_BIN_READ;
      ST_EMIT:     if (sts_i.emit_done) state_d = ST_LOAD;
      default:     state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.store = acc && !full_i;
        cmd_o.flag_drop = acc && full_i;
        cmd_o.step_start = acc && in_last_i;
      end
      ST_DIV_STEP: cmd_o.clr_start = !sts_i.div_busy;
      ST_BIN_READ: cmd_o.bin_start = !sts_i.scan_done;
      ST_BIN_DIV:  cmd_o.bin_commit = !sts_i.div_busy;
      ST_EMIT: begin
        cmd_o.emit_load = sts_i.out_free && !sts_i.emit_done;
        cmd_o.set_clear = sts_i.emit_done;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_LOAD;
    else state_q <= state_d;
  end

  `EWH_ASSERT(a_ready_load, clk_i, rst_ni, in_ready_o |-> state_q == ST_LOAD, "ready off load")
  `EWH_ASSERT(a_last_div, clk_i, rst_ni, (acc && in_last_i) |=> state_q == ST_DIV_STEP, "no div")
  `EWH_ASSERT(a_excl, clk_i, rst_ni, !(cmd_o.store && cmd_o.flag_drop), "store and drop")
endmodule

@@ hw/rtl/ewh_dp.sv @@
// datapath: sample memory, min/max, divider, bin counters, output register
// depends on ewh_pkg, ewh_div
module ewh_dp #(
  parameter int unsigned MaxSamples = 4096,
  parameter int unsigned MaxBins = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ewh_pkg::cmd_t                cmd_i,
  output ewh_pkg::sts_t                sts_o,
  input  logic [ewh_pkg::SampleW-1:0]  sample_i,
  input  logic [ewh_pkg::BinCfgW-1:0]  bin_count_i,
  output logic                         full_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ewh_pkg::BinIdxW-1:0]  bin_index_o,
  output logic [ewh_pkg::SampleW-1:0]  lower_edge_o,
  output logic [ewh_pkg::SampleW-1:0]  upper_edge_o,
  output logic [ewh_pkg::CountW-1:0]   bin_total_o,
  output logic                         last_bin_o,
  output logic                         samples_dropped_o
);
  import ewh_pkg::*;
  `include "equal_width_histogram_core_macros.svh"
  localparam int unsigned AW = (MaxSamples > 1) ? $clog2(MaxSamples) : 1;
  localparam int unsigned NW = $clog2(MaxSamples + 1);
  localparam int unsigned BW = (MaxBins > 1) ? $clog2(MaxBins) : 1;
  localparam int unsigned BCW = $clog2(MaxBins + 1);

  logic [SampleW-1:0] mem [MaxSamples];
  logic [SampleW-1:0] rd_q;
  logic [NW-1:0] cnt_q, ptr_q;
  logic [SampleW-1:0] min_q, max_q, step_q;
  logic ovf_q;
  logic [CountW-1:0] bins_q [MaxBins];
  logic [BCW-1:0] nb_q, nb_d, emit_q, clr_q;
  logic div_busy, div_start, step_phase_q;
  logic [31:0] div_num, div_den, quo;
  logic [BW-1:0] bsel;
  logic [BCW-1:0] bidx_c;
  logic [SampleW-1:0] lo_q;
  logic bin_wr_q;
  logic [BW-1:0] bin_waddr_q;
  logic [CountW-1:0] bin_rd_q;

  assign full_o = (cnt_q == NW'(MaxSamples));

  always_comb begin
    nb_d = BCW'(MaxBins);
    if (bin_count_i == '0) nb_d = BCW'(1);
    else if ({25'd0, bin_count_i} < 32'(MaxBins)) nb_d = BCW'(bin_count_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) mem[cnt_q[AW-1:0]] <= sample_i;
    rd_q <= mem[ptr_q[AW-1:0]];
  end

  // divider serves step = range/nb, then (x-min)/step per sample
  assign div_start = cmd_i.step_start || (cmd_i.bin_start && step_q != '0);
  always_comb begin
    if (cmd_i.step_start) begin
      div_num = (cmd_i.store ? ((($signed(sample_i) > $signed(max_q)) ? sample_i : max_q)
               - (($signed(sample_i) < $signed(min_q)) ? sample_i : min_q))
               : (max_q - min_q));
      div_den = 32'(nb_d);
    end else begin
      div_num = rd_q - min_q;
      div_den = step_q;
    end
  end
  ewh_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(div_den), .busy_o(div_busy), .quo_o(quo));

  always_comb begin
    bidx_c = nb_q - BCW'(1);
    if (step_q != '0 && quo < 32'(nb_q)) bidx_c = BCW'(quo);
  end
  assign bsel = bidx_c[BW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; ptr_q <= '0; ovf_q <= 1'b0; step_phase_q <= 1'b0;
      min_q <= 32'h7FFF_FFFF; max_q <= 32'h8000_0000;
      nb_q <= BCW'(1); emit_q <= '0; clr_q <= '0; out_valid_o <= 1'b0;
      bin_wr_q <= 1'b0;
    end else begin
      bin_wr_q <= cmd_i.bin_commit;
      if (cmd_i.store) begin
        cnt_q <= cnt_q + NW'(1);
        if ($signed(sample_i) < $signed(min_q)) min_q <= sample_i;
        if ($signed(sample_i) > $signed(max_q)) max_q <= sample_i;
      end
      if (cmd_i.flag_drop) ovf_q <= 1'b1;
      if (cmd_i.step_start) begin
        nb_q <= nb_d; step_phase_q <= 1'b1;
      end
      if (cmd_i.clr_start) begin
        step_phase_q <= 1'b0; clr_q <= '0; ptr_q <= '0;
      end else if (clr_q != BCW'(MaxBins)) clr_q <= clr_q + BCW'(1);
      if (cmd_i.bin_start) ptr_q <= ptr_q + NW'(1);
      if (cmd_i.emit_load) begin
        out_valid_o <= 1'b1;
        emit_q <= emit_q + BCW'(1);
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      if (cmd_i.set_clear) begin
        cnt_q <= '0; ptr_q <= '0; ovf_q <= 1'b0; emit_q <= '0;
        min_q <= 32'h7FFF_FFFF; max_q <= 32'h8000_0000;
      end
    end
  end

  // bin update is read in one cycle, written back the next
  always_ff @(posedge clk_i) begin
    if (step_phase_q && !div_busy) step_q <= quo;
    if (cmd_i.clr_start) lo_q <= min_q;
    bin_rd_q <= bins_q[bsel];
    bin_waddr_q <= bsel;
    if (clr_q != BCW'(MaxBins)) bins_q[clr_q[BW-1:0]] <= '0;
    else if (bin_wr_q && bin_rd_q != CountSat) bins_q[bin_waddr_q] <= bin_rd_q + 1'b1;
    if (cmd_i.emit_load) begin
      bin_index_o <= BinIdxW'(emit_q);
      lower_edge_o <= lo_q;
      upper_edge_o <= lo_q + step_q;
      lo_q <= lo_q + step_q;
      bin_total_o <= bins_q[emit_q[BW-1:0]];
      last_bin_o <= (emit_q == nb_q - BCW'(1));
      samples_dropped_o <= ovf_q;
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.clr_done = (clr_q == BCW'(MaxBins));
  assign sts_o.scan_done = (ptr_q == cnt_q);
  assign sts_o.out_free = !out_valid_o || out_ready_i;
  assign sts_o.emit_done = sts_o.out_free && (emit_q == nb_q);

  `EWH_ASSERT(a_cnt_max, clk_i, rst_ni, cnt_q <= NW'(MaxSamples), "count past capacity")
  `EWH_ASSERT(a_ptr, clk_i, rst_ni, ptr_q <= cnt_q, "read past stored")
  `EWH_ASSERT(a_emit, clk_i, rst_ni, emit_q <= nb_q, "emit past bins")
endmodule

@@ hw/rtl/equal_width_histogram_core.sv @@
// Equal-width histogram core. Samples load at one per cycle into an on-chip
// sample memory while min and max are tracked; the last sample starts binning.
// Binning runs the step division, clears the counters, then divides each
// stored sample through the one shared radix-2 divider (no division when the
// step is zero), closes the scan, then emits one result per bin, held while
// the result side stalls. No input is taken meanwhile.
// Depends on ewh_pkg, ewh_if, ewh_ctrl, ewh_dp, ewh_div.
module equal_width_histogram_core #(
  parameter int unsigned MaxSamples = 4096,
  parameter int unsigned MaxBins = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ewh_pkg::BinCfgW-1:0] cfg_wdata_i,
  ewh_if.sink                         in_ch,
  ewh_if.source                       out_ch
);
  import ewh_pkg::*;
  cmd_t cmd;
  sts_t sts;
  logic full;
  logic [BinCfgW-1:0] bin_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bin_count_q <= BinCountRst;
    else if (cfg_we_i) bin_count_q <= cfg_wdata_i;
  end

  // input data: {sample, last_sample}; output data packed msb first
  ewh_ctrl u_ctrl (.clk_i, .rst_ni, .in_valid_i(in_ch.valid), .in_last_i(in_ch.data[0]),
                   .full_i(full), .in_ready_o(in_ch.ready), .sts_i(sts), .cmd_o(cmd));

  ewh_dp #(.MaxSamples(MaxSamples), .MaxBins(MaxBins)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .sample_i(in_ch.data[32:1]),
    .bin_count_i(bin_count_q), .full_o(full),
    .out_valid_o(out_ch.valid), .out_ready_i(out_ch.ready),
    .bin_index_o(out_ch.data[84:79]), .lower_edge_o(out_ch.data[78:47]),
    .upper_edge_o(out_ch.data[46:15]), .bin_total_o(out_ch.data[14:2]),
    .last_bin_o(out_ch.data[1]), .samples_dropped_o(out_ch.data[0]));
endmodule

@@ tb/equal_width_histogram_core_tb.sv @@
// testbench for the equal-width histogram core: sample sets in, per-bin results out
// depends on ewh_pkg, ewh_if and equal_width_histogram_core
module equal_width_histogram_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ewh_pkg::*;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned BinLimit   = 64;
  localparam int unsigned StallMax   = 17;
  localparam int unsigned WatchLimit = 400000;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last_sample;
  } sample_t;

  typedef struct packed {
    logic [BinIdxW-1:0] bin_index;
    logic [SampleW-1:0] lower_edge;
    logic [SampleW-1:0] upper_edge;
    logic [CountW-1:0]  bin_total;
    logic               last_bin;
    logic               samples_dropped;
  } bin_rec_t;

  class histogram_sb;
    logic [SampleW-1:0] stored[$];
    logic [SampleW-1:0] lo_val, hi_val;
    logic               dropped;
    logic [BinCfgW-1:0] nbins_reg;
    bin_rec_t           pending_bins[$];
    int unsigned        errors, sets, bins_seen;

    function new();
      nbins_reg = BinCountRst;
      errors = 0;
      sets = 0;
      bins_seen = 0;
      clear_set();
    endfunction

    function void clear_set();
      stored.delete();
      lo_val = 32'h7fff_ffff;
      hi_val = 32'h8000_0000;
      dropped = 1'b0;
    endfunction

    function void note_sample(sample_t it);
      int unsigned nb;
      logic [SampleW-1:0] range, step, diff, q;
      logic [CountW-1:0] cnt [BinLimit];
      int unsigned b;
      bin_rec_t r;
      if (stored.size() < StoreDepth) begin
        stored.push_back(it.sample);
        if ($signed(it.sample) < $signed(lo_val)) lo_val = it.sample;
        if ($signed(it.sample) > $signed(hi_val)) hi_val = it.sample;
      end else begin
        dropped = 1'b1;
      end
      if (!it.last_sample) return;
      nb = nbins_reg;
      if (nb == 0) nb = 1;
      if (nb > BinLimit) nb = BinLimit;
      range = hi_val - lo_val;
      step = range / nb;
      foreach (cnt[i]) cnt[i] = '0;
      foreach (stored[i]) begin
        diff = stored[i] - lo_val;
        b = nb - 1;
        if (step != 0) begin
          q = diff / step;
          if (q < nb) b = q;
        end
        if (cnt[b] < CountSat) cnt[b] = cnt[b] + 1'b1;
      end
      for (int unsigned i = 0; i < nb; i++) begin
        r.bin_index = i[BinIdxW-1:0];
        r.lower_edge = lo_val + i * step;
        r.upper_edge = lo_val + (i + 1) * step;
        r.bin_total = cnt[i];
        r.last_bin = (i == nb - 1);
        r.samples_dropped = dropped;
        pending_bins.push_back(r);
      end
      sets++;
      clear_set();
    endfunction

    function void check_bin(bin_rec_t act);
      bin_rec_t e;
      bins_seen++;
      if (pending_bins.size() == 0) begin
        $error("unexpected result transfer: bin_index %0d", act.bin_index);
        errors++;
        return;
      end
      e = pending_bins.pop_front();
      if (act.bin_index !== e.bin_index) begin
        $error("bin_index: expected %0d actual %0d", e.bin_index, act.bin_index);
        errors++;
      end
      if (act.lower_edge !== e.lower_edge) begin
        $error("lower_edge: expected %h actual %h", e.lower_edge, act.lower_edge);
        errors++;
      end
      if (act.upper_edge !== e.upper_edge) begin
        $error("upper_edge: expected %h actual %h", e.upper_edge, act.upper_edge);
        errors++;
      end
      if (act.bin_total !== e.bin_total) begin
        $error("bin_total: expected %0d actual %0d", e.bin_total, act.bin_total);
        errors++;
      end
      if (act.last_bin !== e.last_bin) begin
        $error("last_bin: expected %b actual %b", e.last_bin, act.last_bin);
        errors++;
      end
      if (act.samples_dropped !== e.samples_dropped) begin
        $error("samples_dropped: expected %b actual %b", e.samples_dropped,
               act.samples_dropped);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [BinCfgW-1:0] cfg_wdata_i = '0;

  ewh_if #(.W($bits(sample_t)))  in_if ();
  ewh_if #(.W($bits(bin_rec_t))) out_if ();

  equal_width_histogram_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_if),
    .out_ch      (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  histogram_sb sb = new();
  bit          no_stall = 1'b0;
  int unsigned idle_count = 0;
  int unsigned sent = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
  end

  // watchdog on cycles with no transfer on either channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  // result side with random backpressure
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = no_stall ? 0 : $urandom_range(0, StallMax);
      if (stall > 0) begin
        out_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready = 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      sb.check_bin(bin_rec_t'(out_if.data));
    end
  end

  task automatic send_sample(logic [SampleW-1:0] x, logic last);
    int unsigned gap;
    sample_t it;
    gap = no_stall ? 0 : $urandom_range(0, StallMax);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    it.sample = x;
    it.last_sample = last;
    in_if.data = it;
    in_if.valid = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_sample(it);
    sent++;
    @(negedge clk_i);
  endtask

  // sender holds off until every bin of the previous set is out
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending_bins.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_bins(logic [BinCfgW-1:0] v);
    drain();
    cfg_wdata_i = v;
    cfg_we_i = 1'b1;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    sb.nbins_reg = v;
  endtask

  function automatic logic [SampleW-1:0] pick_value(logic [SampleW-1:0] base, int mode);
    case (mode)
      0: return $urandom();
      1: return base + $urandom_range(0, 40);
      2: return base;
      default: return base + ($urandom() & 32'h000f_ffff);
    endcase
  endfunction

  initial begin
    logic [SampleW-1:0] base;
    int mode, len;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: reset bin count, extremes, single sample, equal values
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'h1234_5678, 1'b1);
    set_bins(7'd1);
    send_sample(32'hffff_ffff, 1'b0);
    send_sample(32'h0001_0000, 1'b1);
    set_bins(7'd0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);
    set_bins(7'd64);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b0);
    send_sample(32'h8000_0001, 1'b0);
    send_sample(32'h0000_0000, 1'b1);
    set_bins(7'd127);
    // range smaller than the bin count gives a zero step
    send_sample(32'h0000_0005, 1'b0);
    send_sample(32'h0000_0009, 1'b0);
    send_sample(32'h0000_0005, 1'b1);
    set_bins(7'd3);
    send_sample(32'h5555_5555, 1'b0);
    send_sample(32'h5555_5555, 1'b1);
    send_sample(32'haaaa_aaaa, 1'b0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h0000_0003, 1'b1);

    // random sets, mostly small, with assorted value spreads
    while (sent < 390) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 5))
          0: set_bins(7'd0);
          1: set_bins(7'd64);
          2: set_bins(7'd127);
          default: set_bins(7'($urandom_range(1, 20)));
        endcase
        no_stall = ($urandom_range(0, 4) == 0);
      end
      base = $urandom();
      mode = $urandom_range(0, 3);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) send_sample(pick_value(base, mode), i == len - 1);
    end

    in_if.valid = 1'b0;
    while (sb.pending_bins.size() != 0) @(negedge clk_i);
    repeat (100) @(negedge clk_i);
    $display("covered %0d sets from %0d samples, %0d bin results checked",
             sb.sets, sent, sb.bins_seen);
    $display("bin counts 0, 1, 3, 64, 127 and random, zero and full-scale ranges");
    if (sb.errors == 0 && sb.pending_bins.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/ewh_pkg.sv
hw/rtl/ewh_if.sv
hw/rtl/ewh_div.sv
hw/rtl/ewh_ctrl.sv
hw/rtl/ewh_dp.sv
hw/rtl/equal_width_histogram_core.sv
tb/equal_width_histogram_core_tb.sv
